>>> rtl/dlpd_pkg.sv
`timescale 1ns / 1ps

package dlpd_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0]  CFG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_PLANE_MODE   = 1'b1;
    localparam logic [CFG_DATA_W-1:0] LINE_WIDTH_RESET = 11'd320;

    localparam logic [7:0]  STORE_PRESET      = 8'h80;
    localparam logic [15:0] STORE_PAIR_PRESET = {STORE_PRESET, STORE_PRESET};

    typedef struct packed {
        logic [7:0] code_byte;
        logic       frame_start;
    } code_req_t;

    typedef struct packed {
        logic [7:0] left_pixel;
        logic [7:0] right_pixel;
        logic       end_of_line;
        logic       odd_row;
    } pix_req_t;

    typedef struct packed {
        logic [7:0] code;
        logic       first;
        logic       last;
        logic       green_even;
        logic       odd_row;
    } pair_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic sweeping;
        logic busy;
        logic clean;
    } back_status_t;

    function automatic logic signed [8:0] delta_of(input logic [3:0] code);
        logic signed [8:0] d;
        unique case (code)
            4'h0: d = -9'sd144;
            4'h1: d = -9'sd110;
            4'h2: d = -9'sd77;
            4'h3: d = -9'sd53;
            4'h4: d = -9'sd35;
            4'h5: d = -9'sd21;
            4'h6: d = -9'sd11;
            4'h7: d = -9'sd3;
            4'h8: d = 9'sd2;
            4'h9: d = 9'sd10;
            4'ha: d = 9'sd20;
            4'hb: d = 9'sd34;
            4'hc: d = 9'sd52;
            4'hd: d = 9'sd76;
            4'he: d = 9'sd110;
            4'hf: d = 9'sd144;
        endcase
        return d;
    endfunction

    function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8:1];
    endfunction

    function automatic logic [7:0] apply_delta(input logic [7:0] pred, input logic [3:0] code);
        logic signed [8:0] d;
        logic signed [9:0] v;
        logic [7:0]        r;
        d = delta_of(code);
        v = $signed({2'b00, pred}) + $signed({d[8], d});
        if (v[9])
        begin
            r = 8'h00;
        end
        else if (v[8])
        begin
            r = 8'hff;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/dpcm_line_predictive_decoder.sv
`timescale 1ns / 1ps

// pix_valid rises once a request has passed the two-slot queue, read stage and output register.
// Throughput: one request per cycle (single-port store write) unless pix_ready or a sweep stalls.
// A frame_start request waits until earlier requests have left the back end; if the
// store was written since its last preset, a sweep presets all MAX_LINE_PIXELS/2 entries first.
// Reset: rst_n clears control state, then the same sweep presets all MAX_LINE_PIXELS/2 entries.
module dpcm_line_predictive_decoder
    import dlpd_pkg::*;
#(
    parameter int MAX_LINE_PIXELS = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  code_valid,
    output logic                  code_ready,
    input  code_req_t             code_data,
    output logic                  pix_valid,
    input  logic                  pix_ready,
    output pix_req_t              pix_data
);

    localparam int IDX_W  = $clog2(MAX_LINE_PIXELS / 2);
    localparam int DATA_W = IDX_W + $bits(pair_ctl_t);

    logic              push;
    logic [DATA_W-1:0] push_data;
    logic              pop;
    logic [DATA_W-1:0] pop_data;
    logic              clear_req;
    q_status_t         qs;
    back_status_t      bs;

    assign cfg_ready = 1'b1;

    dlpd_front #(
        .MAX_LINE_PIXELS (MAX_LINE_PIXELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code_data  (code_data),
        .push       (push),
        .push_data  (push_data),
        .qs         (qs),
        .bs         (bs),
        .clear_req  (clear_req)
    );

    dlpd_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qs        (qs)
    );

    dlpd_back #(
        .MAX_LINE_PIXELS (MAX_LINE_PIXELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (pop_data),
        .qs        (qs),
        .pop       (pop),
        .clear_req (clear_req),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .bs        (bs)
    );

endmodule

>>> rtl/dlpd_queue.sv
`timescale 1ns / 1ps

module dlpd_queue
    import dlpd_pkg::*;
#(
    parameter int DATA_W = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output q_status_t         qs
);

    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = slot_reg[rd_ptr_reg];
    assign qs.full  = (count_reg == 2'd2);
    assign qs.empty = (count_reg == 2'd0);

endmodule

>>> rtl/dlpd_front.sv
`timescale 1ns / 1ps

module dlpd_front
    import dlpd_pkg::*;
#(
    parameter int MAX_LINE_PIXELS = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  code_valid,
    output logic                  code_ready,
    input  code_req_t             code_data,
    output logic                  push,
    output logic [$clog2(MAX_LINE_PIXELS/2)+$bits(pair_ctl_t)-1:0] push_data,
    input  q_status_t             qs,
    input  back_status_t          bs,
    output logic                  clear_req
);

    localparam int HALF  = MAX_LINE_PIXELS / 2;
    localparam int IDX_W = $clog2(HALF);
    localparam int CNT_W = $clog2(HALF + 1);
    localparam int CMP_W = (CNT_W > CFG_DATA_W - 1) ? CNT_W : CFG_DATA_W - 1;

    logic [CFG_DATA_W-1:0] line_width_reg;
    logic                  plane_mode_reg;
    logic [IDX_W-1:0]      col_reg;
    logic                  row_reg;
    logic [IDX_W-1:0]      col_next;
    logic                  row_next;

    logic [CMP_W-1:0] raw_pairs;
    logic [CMP_W-1:0] pairs;
    logic [CMP_W-1:0] col_ext;
    logic [CMP_W-1:0] col_eff;
    logic             row_cur;
    logic             last;
    pair_ctl_t        ctl;

    always_comb
    begin
        raw_pairs = CMP_W'(line_width_reg[CFG_DATA_W-1:1]);
        if (raw_pairs == '0)
        begin
            pairs = CMP_W'(1);
        end
        else if (raw_pairs > CMP_W'(HALF))
        begin
            pairs = CMP_W'(HALF);
        end
        else
        begin
            pairs = raw_pairs;
        end

        col_ext = code_data.frame_start ? '0 : CMP_W'(col_reg);
        col_eff = (col_ext >= pairs) ? '0 : col_ext;
        row_cur = code_data.frame_start ? 1'b0 : row_reg;
        last    = (col_eff == pairs - CMP_W'(1));

        ctl.code       = code_data.code_byte;
        ctl.first      = (col_eff == '0);
        ctl.last       = last;
        ctl.green_even = plane_mode_reg && !row_cur;
        ctl.odd_row    = row_cur;

        col_next = last ? '0 : IDX_W'(col_eff + CMP_W'(1));
        row_next = row_cur ^ last;
    end

    assign code_ready = !qs.full && !bs.sweeping
                        && (!code_data.frame_start || (bs.clean && qs.empty && !bs.busy));
    assign push       = code_valid && code_ready;
    assign push_data  = {col_eff[IDX_W-1:0], ctl};
    assign clear_req  = code_valid && code_data.frame_start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
            plane_mode_reg <= 1'b0;
            col_reg        <= '0;
            row_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_LINE_WIDTH: line_width_reg <= cfg_data;
                    CFG_PLANE_MODE: plane_mode_reg <= cfg_data[0];
                endcase
            end
            if (push)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

endmodule

>>> rtl/dlpd_back.sv
`timescale 1ns / 1ps

module dlpd_back
    import dlpd_pkg::*;
#(
    parameter int MAX_LINE_PIXELS = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [$clog2(MAX_LINE_PIXELS/2)+$bits(pair_ctl_t)-1:0] q_data,
    input  q_status_t    qs,
    output logic         pop,
    input  logic         clear_req,
    output logic         pix_valid,
    input  logic         pix_ready,
    output pix_req_t     pix_data,
    output back_status_t bs
);

    localparam int HALF  = MAX_LINE_PIXELS / 2;
    localparam int IDX_W = $clog2(HALF);
    localparam int CTL_W = $bits(pair_ctl_t);

    logic [15:0] store_mem [HALF];

    logic             b_valid_reg;
    logic [IDX_W-1:0] b_idx_reg;
    pair_ctl_t        b_ctl_reg;
    logic [15:0]      rd_a_reg;
    logic [15:0]      rd_b_reg;
    logic             wb_valid_reg;
    logic [IDX_W-1:0] wb_idx_reg;
    logic [15:0]      wb_data_reg;
    logic [7:0]       left_reg;
    logic             sweeping_reg;
    logic [IDX_W-1:0] sweep_idx_reg;
    logic             clean_reg;
    logic             out_valid_reg;
    pix_req_t         out_reg;

    logic [IDX_W-1:0] q_idx;
    pair_ctl_t        q_ctl;
    logic             b_fire;
    logic             b_load;
    logic             sweep_start;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [15:0]      mem_wdata;
    logic [IDX_W-1:0] b_idx_up;
    logic [15:0]      word_a;
    logic [15:0]      word_b;
    logic [7:0]       pred_l;
    logic [7:0]       pred_r;
    logic [7:0]       l_pix;
    logic [7:0]       r_pix;

    assign q_idx       = q_data[IDX_W+CTL_W-1:CTL_W];
    assign q_ctl       = pair_ctl_t'(q_data[CTL_W-1:0]);
    assign b_fire      = b_valid_reg && (!out_valid_reg || pix_ready);
    assign b_load      = !qs.empty && !sweeping_reg && (!b_valid_reg || b_fire);
    assign pop         = b_load;
    assign sweep_start = clear_req && qs.empty && !b_valid_reg && !sweeping_reg && !clean_reg;
    assign b_idx_up    = b_idx_reg + IDX_W'(1);

    assign mem_we    = sweeping_reg || b_fire;
    assign mem_waddr = sweeping_reg ? sweep_idx_reg : b_idx_reg;
    assign mem_wdata = sweeping_reg ? STORE_PAIR_PRESET : {r_pix, l_pix};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (b_load)
        begin
            rd_a_reg <= store_mem[q_idx];
            rd_b_reg <= store_mem[q_idx + IDX_W'(1)];
        end
    end

    always_comb
    begin
        word_a = (wb_valid_reg && wb_idx_reg == b_idx_reg) ? wb_data_reg : rd_a_reg;
        word_b = (wb_valid_reg && wb_idx_reg == b_idx_up) ? wb_data_reg : rd_b_reg;

        if (b_ctl_reg.green_even)
        begin
            pred_l = b_ctl_reg.first ? avg8(word_a[7:0], word_a[15:8])
                                     : avg8(word_a[15:8], left_reg);
        end
        else
        begin
            pred_l = b_ctl_reg.first ? word_a[7:0] : avg8(word_a[7:0], left_reg);
        end
        l_pix = apply_delta(pred_l, b_ctl_reg.code[3:0]);

        pred_r = (b_ctl_reg.green_even && !b_ctl_reg.last) ? avg8(word_b[7:0], l_pix)
                                                             : avg8(word_a[15:8], l_pix);
        r_pix  = apply_delta(pred_r, b_ctl_reg.code[7:4]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            wb_valid_reg  <= 1'b0;
            left_reg      <= 8'h00;
            sweeping_reg  <= 1'b1;
            sweep_idx_reg <= '0;
            clean_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_load)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_fire)
            begin
                b_valid_reg <= 1'b0;
            end

            if (b_fire)
            begin
                out_valid_reg <= 1'b1;
                left_reg      <= r_pix;
                clean_reg     <= 1'b0;
            end
            else if (pix_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (sweeping_reg)
            begin
                wb_valid_reg  <= 1'b0;
                sweep_idx_reg <= sweep_idx_reg + IDX_W'(1);
                if (sweep_idx_reg == IDX_W'(HALF - 1))
                begin
                    sweeping_reg <= 1'b0;
                    clean_reg    <= 1'b1;
                end
            end
            else if (sweep_start)
            begin
                sweeping_reg <= 1'b1;
            end
            else if (b_fire)
            begin
                wb_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_idx_reg <= q_idx;
            b_ctl_reg <= q_ctl;
        end
        if (b_fire)
        begin
            wb_idx_reg          <= b_idx_reg;
            wb_data_reg         <= {r_pix, l_pix};
            out_reg.left_pixel  <= l_pix;
            out_reg.right_pixel <= r_pix;
            out_reg.end_of_line <= b_ctl_reg.last;
            out_reg.odd_row     <= b_ctl_reg.odd_row;
        end
    end

    assign pix_valid   = out_valid_reg;
    assign pix_data    = out_reg;
    assign bs.sweeping = sweeping_reg;
    assign bs.busy     = b_valid_reg;
    assign bs.clean    = clean_reg;

    a_sweep_alone: assert property (@(posedge clk) disable iff (!rst_n)
        sweeping_reg |-> !b_valid_reg && qs.empty)
        else $error("line store sweep overlaps pending requests");

    a_write_dirties: assert property (@(posedge clk) disable iff (!rst_n)
        b_fire |=> !clean_reg)
        else $error("line store marked clean after a pixel write");

    a_sweep_ends_clean: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(sweeping_reg) |-> clean_reg)
        else $error("sweep finished without clean store");

endmodule
